FILE: sv/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform.
package mvt_pkg;

  localparam int unsigned DIM        = 4;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned PROD_W     = 2 * ELEM_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned NUM_WORDS  = 8;
  localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int unsigned CFG_IDX_W  = WORD_IDX_W + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DIM-1:0]          vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [DIM-1:0]          prod_vec_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef sum_t [DIM-1:0]           sum_vec_t;
  typedef logic [WORD_W-1:0]        word_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic      valid;
    vec_t      vec;
    prod_vec_t prod;
    sum_vec_t  sum;
  } stage_t;

  // Identity matrix, two Q16.16 elements per word, row-major.
  localparam word_t MATRIX_RESET [NUM_WORDS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

endpackage

FILE: sv/mvt_in_if.sv
// Input channel: one four-vector per transaction.
interface mvt_in_if
  import mvt_pkg::*;
();
  logic  valid;
  logic  ready;
  elem_t vec_x;
  elem_t vec_y;
  elem_t vec_z;
  elem_t vec_w;

  modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                  input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                  output ready);
endinterface

FILE: sv/mvt_out_if.sv
// Result channel: four transformed elements and a saturation flag per transaction.
interface mvt_out_if
  import mvt_pkg::*;
();
  logic  valid;
  logic  ready;
  elem_t out_x;
  elem_t out_y;
  elem_t out_z;
  elem_t out_w;
  logic  saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

FILE: sv/mvt_cell.sv
// Column cell: one vector element times a matrix column, plus the previous cell's products.
module mvt_cell
  import mvt_pkg::*;
#(
  parameter int unsigned COL = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  vec_t   col_elem,
  input  stage_t stage_i,
  output stage_t stage_o
);

  logic      valid_r;
  vec_t      vec_r;
  prod_vec_t prod_r;
  prod_vec_t prod_nxt;
  sum_vec_t  sum_r;
  sum_vec_t  sum_nxt;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      prod_nxt[r] = $signed(col_elem[r]) * $signed(stage_i.vec[COL]);
      sum_nxt[r]  = $signed(stage_i.sum[r]) + $signed(stage_i.prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= stage_i.vec;
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign stage_o = '{valid: valid_r, vec: vec_r, prod: prod_r, sum: sum_r};

endmodule

FILE: sv/mvt_round.sv
// Final add, floor shift by the fraction width and 32-bit saturation; output register.
module mvt_round
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t stage_i,
  output logic   out_valid,
  output vec_t   out_vec,
  output logic   out_sat
);

  localparam elem_t POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t NEG_MAX = {1'b1, {(ELEM_W-1){1'b0}}};

  logic              valid_r;
  vec_t              res_r;
  vec_t              res_nxt;
  logic              sat_r;
  logic              sat_nxt;
  sum_t              total   [DIM];
  sum_t              shifted [DIM];
  logic [DIM-1:0]    ovf;

  always_comb begin
    sat_nxt = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      total[r]   = $signed(stage_i.sum[r]) + $signed(stage_i.prod[r]);
      shifted[r] = total[r] >>> FRAC_BITS;
      // fits in 32 bits when all upper bits match the sign bit
      ovf[r]     = !((&shifted[r][SUM_W-1:ELEM_W-1]) || !(|shifted[r][SUM_W-1:ELEM_W-1]));
      if (ovf[r]) begin
        res_nxt[r] = shifted[r][SUM_W-1] ? NEG_MAX : POS_MAX;
      end else begin
        res_nxt[r] = shifted[r][ELEM_W-1:0];
      end
      sat_nxt = sat_nxt | ovf[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = res_r;
  assign out_sat   = sat_r;

endmodule

FILE: sv/mat4_vec4_transform.sv
// Top level: 4x4 Q16.16 matrix times four-vector, a chain of column cells.
//
// The matrix sits in eight 64-bit registers written through cfg_we / cfg_index /
// cfg_wdata, two Q16.16 elements per word, row-major; indexes of 8 and above are
// dropped. Write the matrix only while no vector is in flight.
// in_if carries one four-vector per transaction, out_if the four row dot products
// plus a flag set when any of them clamped to the 32-bit range.
// Each vector passes four column cells (one multiply per row each, partial sums
// handed along the chain) and one rounding stage that holds the result register.
// Throughput: one vector per cycle while out_if does not stall; the chain has one register stage per cell.
// When out_if stalls, the whole chain holds and in_if.ready drops in the same
// cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) loads the identity matrix and empties the chain.
module mat4_vec4_transform
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mvt_in_if.sink               in_if,
  mvt_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  word_t  matrix_r [NUM_WORDS];
  vec_t   col_elem [DIM];
  stage_t chain    [DIM+1];
  logic   en;
  vec_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        matrix_r[i] <= MATRIX_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_WORDS))) begin
      matrix_r[cfg_index[WORD_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // column c of row r lives in word 2r + c/2, half c%2
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        col_elem[c][r] = matrix_r[r*2 + c/2][(c%2)*ELEM_W +: ELEM_W];
      end
    end
  end

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  assign chain[0] = '{valid: in_if.valid,
                      vec:   {in_if.vec_w, in_if.vec_z, in_if.vec_y, in_if.vec_x},
                      prod:  '0,
                      sum:   '0};

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    mvt_cell #(.COL(c)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .col_elem (col_elem[c]),
      .stage_i  (chain[c]),
      .stage_o  (chain[c+1])
    );
  end

  mvt_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .stage_i   (chain[DIM]),
    .out_valid (out_if.valid),
    .out_vec   (res),
    .out_sat   (out_if.saturated)
  );

  assign out_if.out_x = res[0];
  assign out_if.out_y = res[1];
  assign out_if.out_z = res[2];
  assign out_if.out_w = res[3];

endmodule
